[hdl/three_position_actuator_controller_macros.svh]
// Assertion macros shared by the checker of the three-position actuator controller.
// Stand-alone header; the checker includes it by file name.
`ifndef THREE_POSITION_ACTUATOR_CONTROLLER_MACROS_SVH
`define THREE_POSITION_ACTUATOR_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tpac_pkg.sv]
// Package for the three-position actuator controller: codes, state type and
// the direction-choice function. No dependencies.
`default_nettype none

package tpac_pkg;

    localparam logic [2:0] POS_UNKNOWN        = 3'd0;
    localparam logic [2:0] POS_RETRACTED      = 3'd1;
    localparam logic [2:0] POS_PART_RETRACTED = 3'd2;
    localparam logic [2:0] POS_CENTER         = 3'd3;
    localparam logic [2:0] POS_PART_EXTENDED  = 3'd4;
    localparam logic [2:0] POS_EXTENDED       = 3'd5;

    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    localparam logic CMD_SET_GOAL = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic [7:0] TRAVEL_TICKS_RESET = 8'd38;
    localparam logic [7:0] COUNT_MAX          = 8'hFF;

    typedef struct packed {
        logic [2:0] goal;
        logic [2:0] position;
        logic [1:0] dir;
        logic [7:0] count;
        logic       armed;
    } t_state;

    // Direction that moves the cylinder from position p toward goal g.
    function automatic logic [1:0] pick_dir(input logic [2:0] p, input logic [2:0] g);
        logic [1:0] d;
        d = DIR_OFF;
        if (p == g || g == POS_UNKNOWN) begin
            d = DIR_OFF;
        end else if (g == POS_RETRACTED) begin
            d = DIR_REV;
        end else if (g == POS_PART_RETRACTED) begin
            d = (p == POS_RETRACTED) ? DIR_FWD : DIR_REV;
        end else if (g == POS_CENTER) begin
            d = (p inside {POS_RETRACTED, POS_PART_RETRACTED}) ? DIR_FWD : DIR_REV;
        end else if (g == POS_PART_EXTENDED) begin
            d = (p == POS_EXTENDED) ? DIR_REV : DIR_FWD;
        end else if (g == POS_EXTENDED) begin
            d = DIR_FWD;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/three_position_actuator_controller.sv]
// Three-position actuator controller: top level with input register, state
// and result register. Depends on tpac_pkg and tpac_step.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: i_cmd selects
//   a set-goal command (i_goal) or a poll tick (i_switch_level, low at the
//   centre). Every item yields exactly one result on the output channel
//   (o_out_valid / i_out_ready): valve drive, estimated position, busy flag
//   and the tick count since the current direction began.
//   The travel time in ticks is written through i_cfg_we / i_cfg_data and
//   should only change while no item is in flight.
//   An accepted item passes through the input register and then the result
//   register before its result is shown. One item per cycle is sustained
//   while the output does not stall; the state update is a single short step of compares.
//   A stall on the output holds the result register and then the input
//   register; o_in_ready falls only when both are full and the result is
//   not being taken.
//   Synchronous reset clears the state to unknown goal and position, valve
//   off, count zero, not busy, and reloads the travel time to 38 ticks.
`default_nettype none

module three_position_actuator_controller
    import tpac_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_cmd,
    input  wire [2:0]  i_goal,
    input  wire        i_switch_level,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [1:0] o_valve,
    output logic [2:0] o_position,
    output logic       o_busy_res,
    output logic [7:0] o_elapsed,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data
);

    logic [7:0] r_travel_ticks;
    t_state     r_state;
    t_state     n_state;

    logic       r_s1_valid;
    logic       r_s1_cmd;
    logic [2:0] r_s1_goal;
    logic       r_s1_switch_level;

    logic       r_out_valid;
    t_state     r_out;

    logic       advance;
    logic       accept;

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    tpac_step u_step (
        .i_cur          (r_state),
        .i_cmd          (r_s1_cmd),
        .i_goal         (r_s1_goal),
        .i_switch_level (r_s1_switch_level),
        .i_travel_ticks (r_travel_ticks),
        .o_nxt          (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel_ticks <= TRAVEL_TICKS_RESET;
            r_state        <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_travel_ticks <= i_cfg_data;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd          <= i_cmd;
            r_s1_goal         <= i_goal;
            r_s1_switch_level <= i_switch_level;
        end
        if (advance) begin
            r_out <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valve     = r_out.dir;
    assign o_position  = r_out.position;
    assign o_busy_res  = r_out.armed;
    assign o_elapsed   = r_out.count;

endmodule

`default_nettype wire

[hdl/tpac_step.sv]
// Next-state logic of the actuator controller for one item.
// Depends on tpac_pkg.
`default_nettype none

module tpac_step
    import tpac_pkg::*;
(
    input  var t_state     i_cur,
    input  wire            i_cmd,
    input  wire [2:0]      i_goal,
    input  wire            i_switch_level,
    input  wire [7:0]      i_travel_ticks,
    output t_state         o_nxt
);

    logic [1:0] set_dir;
    logic [7:0] tick_cnt;
    logic       timed_out;
    logic [2:0] est_pos;
    logic [1:0] tick_dir;

    assign set_dir   = pick_dir(i_cur.position, i_goal);
    assign tick_cnt  = (i_cur.count == COUNT_MAX) ? i_cur.count : i_cur.count + 8'd1;
    assign timed_out = (tick_cnt >= i_travel_ticks);
    assign tick_dir  = pick_dir(est_pos, i_cur.goal);

    // The centre switch overrides the timer; otherwise the estimate steps one position along
    // the current direction from an end or the centre, or jumps to the end on time-out.
    always_comb begin
        est_pos = i_cur.position;
        if (!i_switch_level) begin
            est_pos = POS_CENTER;
        end else if (i_cur.dir == DIR_FWD) begin
            if (timed_out) begin
                est_pos = POS_EXTENDED;
            end else if (i_cur.position == POS_RETRACTED) begin
                est_pos = POS_PART_RETRACTED;
            end else if (i_cur.position == POS_CENTER) begin
                est_pos = POS_PART_EXTENDED;
            end
        end else if (i_cur.dir == DIR_REV) begin
            if (timed_out) begin
                est_pos = POS_RETRACTED;
            end else if (i_cur.position == POS_EXTENDED) begin
                est_pos = POS_PART_EXTENDED;
            end else if (i_cur.position == POS_CENTER) begin
                est_pos = POS_PART_RETRACTED;
            end
        end
    end

    always_comb begin
        o_nxt = i_cur;
        if (i_cmd == CMD_SET_GOAL) begin
            if (i_goal != i_cur.goal) begin
                o_nxt.goal  = i_goal;
                o_nxt.armed = (set_dir != DIR_OFF);
                if (set_dir != i_cur.dir) begin
                    o_nxt.dir   = set_dir;
                    o_nxt.count = '0;
                end
            end
        end else if (i_cur.armed) begin
            o_nxt.count    = tick_cnt;
            o_nxt.position = est_pos;
            if (timed_out) begin
                // A timed-out stop keeps the count.
                o_nxt.armed = 1'b0;
                o_nxt.dir   = DIR_OFF;
            end else begin
                if (tick_dir != i_cur.dir) begin
                    o_nxt.dir   = tick_dir;
                    o_nxt.count = '0;
                end
                if (tick_dir == DIR_OFF) begin
                    o_nxt.armed = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/tpac_checker.sv]
// Port-level checker for the three-position actuator controller, bound to
// the top level. Depends on tpac_pkg and the assertion macro header.
`default_nettype none
`include "three_position_actuator_controller_macros.svh"

module tpac_checker
    import tpac_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [1:0] o_valve,
    input wire [2:0] o_position,
    input wire       o_busy_res,
    input wire [7:0] o_elapsed
);

    logic        busy_ok;
    logic        valve_ok;
    logic        pos_ok;
    logic        stall;
    logic [13:0] res;

    assign busy_ok  = (o_busy_res == (o_valve != DIR_OFF));
    assign valve_ok = (o_valve == DIR_OFF) || (o_valve == DIR_FWD) || (o_valve == DIR_REV);
    assign pos_ok   = (o_position <= POS_EXTENDED);
    assign stall    = o_out_valid && !i_out_ready;
    assign res      = {o_valve, o_position, o_busy_res, o_elapsed};

    // The block is busy exactly while the valve is driven.
    `TPAC_ASSERT_NOW(a_busy_matches_valve, i_clk, i_rst_n, o_out_valid, busy_ok, "busy vs valve")

    `TPAC_ASSERT_NOW(a_valve_code, i_clk, i_rst_n, o_out_valid, valve_ok, "invalid valve code")

    // The estimate only ever takes one of the six defined positions.
    `TPAC_ASSERT_NOW(a_position_code, i_clk, i_rst_n, o_out_valid, pos_ok, "invalid position")

    `TPAC_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, stall, o_out_valid && $stable(res), "stall")

endmodule

bind three_position_actuator_controller tpac_checker u_tpac_checker (.*);

`default_nettype wire
